// ----- design/tpc_pkg.sv -----
// Shared types and constants for the trackball pulse and click unit.
`default_nettype none
package tpc_pkg;

  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_PULSE  = 3'd1,
    KIND_READ_V = 3'd2,
    KIND_READ_H = 3'd3,
    KIND_POLL   = 3'd4
  } kind_t;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam int CFG_BITS    = 20;
  localparam int DELTA_BITS  = 17;
  localparam int DELTA_LIMIT = 65535;

  localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET = 20'd20000;
  localparam logic [CFG_BITS-1:0] LONG_RESET     = 20'd500000;

  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_LONG     = 1'b1;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] direction;
    logic       click_level;
  } item_t;

  typedef struct packed {
    logic signed [DELTA_BITS-1:0] scroll_delta;
    logic                         click_seen;
    logic                         long_press;
  } result_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] debounce_floor;
    logic [CFG_BITS-1:0] long_press_limit;
  } cfg_t;

endpackage
`default_nettype wire

// ----- design/trackball_pulse_and_click_unit.sv -----
// Top level: input register, state update stage and result register.
// An accepted transaction moves from the input register to the result register.
// Throughput: one transaction per cycle unless stalled; state update is combinational.
// A full result register that is not taken stalls the input register and then item_ready.
// Synchronous reset clears counters and timer, marks the button released,
// reloads both limits to their defaults and empties both stages.
`default_nettype none
module trackball_pulse_and_click_unit #(
  parameter int COUNT_BITS = 16,
  parameter int TIMER_BITS = 20
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire tpc_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output tpc_pkg::result_t      result,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import tpc_pkg::*;

  logic    stage_valid;
  item_t   stage_item;
  logic    advance;
  cfg_t    cfg;
  result_t result_next;

  assign advance    = stage_valid && (!result_valid || result_ready);
  assign item_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      stage_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  tpc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tpc_core #(
    .COUNT_BITS (COUNT_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (stage_item),
    .cfg         (cfg),
    .result_next (result_next)
  );

endmodule
`default_nettype wire

// ----- design/tpc_cfg_regs.sv -----
// APB register file holding the debounce floor and long-press limit.
`default_nettype none
module tpc_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output tpc_pkg::cfg_t     cfg
);
  import tpc_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_floor   <= DEBOUNCE_RESET;
      cfg.long_press_limit <= LONG_RESET;
    end else if (wr) begin
      case (paddr[2])
        REG_DEBOUNCE: cfg.debounce_floor   <= pwdata[CFG_BITS-1:0];
        REG_LONG:     cfg.long_press_limit <= pwdata[CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DEBOUNCE: prdata = {{(32-CFG_BITS){1'b0}}, cfg.debounce_floor};
      REG_LONG:     prdata = {{(32-CFG_BITS){1'b0}}, cfg.long_press_limit};
      default:      prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/tpc_core.sv -----
// Pulse counters, press timer and result logic for one transaction.
`default_nettype none
module tpc_core #(
  parameter int COUNT_BITS = 16,
  parameter int TIMER_BITS = 20
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire tpc_pkg::item_t  item,
  input  wire tpc_pkg::cfg_t   cfg,
  output tpc_pkg::result_t     result_next
);
  import tpc_pkg::*;

  localparam int DW = (COUNT_BITS + 2 > DELTA_BITS + 1) ? COUNT_BITS + 2 : DELTA_BITS + 1;
  localparam int TW = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
  localparam logic signed [DW-1:0] LIM_POS = DW'(DELTA_LIMIT);
  localparam logic signed [DW-1:0] LIM_NEG = -DW'(DELTA_LIMIT);

  logic [COUNT_BITS-1:0] up_pulses, down_pulses, left_pulses, right_pulses;
  logic [COUNT_BITS-1:0] up_pulses_next, down_pulses_next;
  logic [COUNT_BITS-1:0] left_pulses_next, right_pulses_next;
  logic                  prior_button_level, prior_button_level_next;
  logic [TIMER_BITS-1:0] press_ticks, press_ticks_next;

  logic [COUNT_BITS-1:0] plus, minus;
  logic signed [DW-1:0]  diff, clamped;
  logic [TW-1:0]         ticks_x, long_x, floor_x;

  function automatic logic [COUNT_BITS-1:0] cnt_inc(input logic [COUNT_BITS-1:0] v);
    cnt_inc = (v == '1) ? v : v + 1'b1;
  endfunction

  always_comb begin
    plus  = (item.kind == KIND_READ_V) ? up_pulses : right_pulses;
    minus = (item.kind == KIND_READ_V) ? down_pulses : left_pulses;
    diff  = signed'({{(DW-COUNT_BITS){1'b0}}, plus})
          - signed'({{(DW-COUNT_BITS){1'b0}}, minus});
    if (diff > LIM_POS)      clamped = LIM_POS;
    else if (diff < LIM_NEG) clamped = LIM_NEG;
    else                     clamped = diff;
    ticks_x = TW'(press_ticks);
    long_x  = TW'(cfg.long_press_limit);
    floor_x = TW'(cfg.debounce_floor);
  end

  always_comb begin
    up_pulses_next          = up_pulses;
    down_pulses_next        = down_pulses;
    left_pulses_next        = left_pulses;
    right_pulses_next       = right_pulses;
    prior_button_level_next = prior_button_level;
    press_ticks_next        = press_ticks;
    result_next             = '0;
    case (item.kind)
      KIND_TICK: begin
        if (!prior_button_level && press_ticks != '1) begin
          press_ticks_next = press_ticks + 1'b1;
        end
      end
      KIND_PULSE: begin
        case (item.direction)
          DIR_UP:    up_pulses_next    = cnt_inc(up_pulses);
          DIR_DOWN:  down_pulses_next  = cnt_inc(down_pulses);
          DIR_LEFT:  left_pulses_next  = cnt_inc(left_pulses);
          DIR_RIGHT: right_pulses_next = cnt_inc(right_pulses);
          default: ;
        endcase
      end
      KIND_READ_V: begin
        result_next.scroll_delta = clamped[DELTA_BITS-1:0];
        up_pulses_next           = '0;
        down_pulses_next         = '0;
      end
      KIND_READ_H: begin
        result_next.scroll_delta = clamped[DELTA_BITS-1:0];
        left_pulses_next         = '0;
        right_pulses_next        = '0;
      end
      KIND_POLL: begin
        if (!item.click_level && prior_button_level) begin
          press_ticks_next = '0;
        end else if (item.click_level && !prior_button_level) begin
          if (ticks_x > long_x)       result_next.long_press = 1'b1;
          else if (ticks_x > floor_x) result_next.click_seen = 1'b1;
        end
        prior_button_level_next = item.click_level;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      up_pulses          <= '0;
      down_pulses        <= '0;
      left_pulses        <= '0;
      right_pulses       <= '0;
      prior_button_level <= 1'b1;
      press_ticks        <= '0;
    end else if (advance) begin
      up_pulses          <= up_pulses_next;
      down_pulses        <= down_pulses_next;
      left_pulses        <= left_pulses_next;
      right_pulses       <= right_pulses_next;
      prior_button_level <= prior_button_level_next;
      press_ticks        <= press_ticks_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/tpc_checker.sv -----
// Port-level checks for the trackball pulse and click unit, bound to the top level.
`default_nettype none
module tpc_assertions (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             result_valid,
  input wire logic             result_ready,
  input wire tpc_pkg::result_t result,
  input wire logic             pready
);
  import tpc_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.click_seen && result.long_press))
    else $error("click and long press reported together");

  a_flags_no_delta: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.click_seen || result.long_press) |-> result.scroll_delta == '0)
    else $error("button report carries movement");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && pready)
    else $error("result pending after reset");

endmodule

bind trackball_pulse_and_click_unit tpc_assertions u_tpc_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result),
  .pready       (pready)
);
`default_nettype wire
